// File: src/tap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_pkg: shared types and constants
// Mode codes, register indexes, reset values and stage bundles for the
// timed actuator position controller.
// ----------------------------------------------------------------------------
package tap_pkg;

    localparam int POS_W   = 16;   // position, target, travel, elapsed
    localparam int PULSE_W = 12;   // servo pulse widths
    localparam int MODE_W  = 3;
    localparam int PCT_W   = 7;    // saturated percent 0..100
    localparam int PROD_W  = PCT_W + POS_W;

    // x / 100 == (x * RECIP) >> RECIP_SHIFT, exact for x < 2**PROD_W
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam int QUOT_W      = PROD_W + RECIP_W;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam logic [POS_W-1:0]   TRAVEL_RESET  = 16'd15000;
    localparam logic [PULSE_W-1:0] STOP_RESET    = 12'd1500;
    localparam logic [PULSE_W-1:0] FORWARD_RESET = 12'd2000;
    localparam logic [PULSE_W-1:0] REVERSE_RESET = 12'd1000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED = 3'd0,
        MODE_OPENING = 3'd1,
        MODE_CLOSING = 3'd2,
        MODE_HOMING  = 3'd3,
        MODE_BOOT    = 3'd4
    } mode_t;

    typedef struct packed {
        logic [POS_W-1:0]   travel_time_ms;
        logic [PULSE_W-1:0] stop_pulse_us;
        logic [PULSE_W-1:0] forward_pulse_us;
        logic [PULSE_W-1:0] reverse_pulse_us;
    } cfg_t;

    // request as held between the input and the update stage
    typedef struct packed {
        logic              cmd;
        logic [PROD_W-1:0] scaled;      // percent * travel, not yet / 100
        logic [POS_W-1:0]  elapsed_ms;
        logic              switch_open;
        logic              switch_closed;
    } item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] motor_pulse_us;
        logic [MODE_W-1:0]  motion_state;
        logic [POS_W-1:0]   position_ms;
        logic [POS_W-1:0]   target_ms;
        logic               homing_done;
        logic               command_ignored;
    } result_t;

endpackage

// File: src/tap_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_cfg_regs: configuration register file
// Four registers written by index; always ready.
// ----------------------------------------------------------------------------
module tap_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [tap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tap_pkg::POS_W-1:0]      cfg_wdata,
    output tap_pkg::cfg_t                  cfg
);

    tap_pkg::cfg_t cfg_reg;
    tap_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tap_pkg::CFG_TRAVEL:  cfg_next.travel_time_ms   = cfg_wdata;
                tap_pkg::CFG_STOP:
                    cfg_next.stop_pulse_us    = cfg_wdata[tap_pkg::PULSE_W-1:0];
                tap_pkg::CFG_FORWARD:
                    cfg_next.forward_pulse_us = cfg_wdata[tap_pkg::PULSE_W-1:0];
                tap_pkg::CFG_REVERSE:
                    cfg_next.reverse_pulse_us = cfg_wdata[tap_pkg::PULSE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.travel_time_ms   <= tap_pkg::TRAVEL_RESET;
            cfg_reg.stop_pulse_us    <= tap_pkg::STOP_RESET;
            cfg_reg.forward_pulse_us <= tap_pkg::FORWARD_RESET;
            cfg_reg.reverse_pulse_us <= tap_pkg::REVERSE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/tap_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_in_stage: input register
// Saturates the percent, scales it by travel time and holds the request.
// ----------------------------------------------------------------------------
module tap_in_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       cmd,
    input  logic signed [7:0]          percent,
    input  logic [tap_pkg::POS_W-1:0]  elapsed_ms,
    input  logic                       switch_open,
    input  logic                       switch_closed,
    input  logic [tap_pkg::POS_W-1:0]  travel_time_ms,
    output logic                       item_valid,
    input  logic                       item_take,
    output tap_pkg::item_t             item
);

    logic                           valid_reg;
    logic                           valid_next;
    tap_pkg::item_t                 item_reg;
    logic [tap_pkg::PCT_W-1:0]      pct_sat;
    logic                           load;

    always_comb begin
        if (percent[7]) begin
            pct_sat = '0;
        end else if (percent[6:0] > tap_pkg::PCT_MAX) begin
            pct_sat = tap_pkg::PCT_MAX;
        end else begin
            pct_sat = percent[6:0];
        end
    end

    assign s_ready = !valid_reg || item_take;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.cmd           <= cmd;
            item_reg.scaled        <= tap_pkg::PROD_W'(pct_sat)
                                      * tap_pkg::PROD_W'(travel_time_ms);
            item_reg.elapsed_ms    <= elapsed_ms;
            item_reg.switch_open   <= switch_open;
            item_reg.switch_closed <= switch_closed;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: src/tap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_core: motion update and result register
// Holds mode, position and target; computes the next state from one request
// and registers the result.
// ----------------------------------------------------------------------------
module tap_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tap_pkg::cfg_t        cfg,
    input  logic                 item_valid,
    output logic                 item_take,
    input  tap_pkg::item_t       item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tap_pkg::result_t     result
);

    localparam int WORK_W = tap_pkg::POS_W + 2;   // signed, holds pos +/- dt

    tap_pkg::mode_t                 mode_reg, mode_next;
    logic [tap_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [tap_pkg::POS_W-1:0]      tgt_reg, tgt_next;
    logic                           out_valid_reg, out_valid_next;
    tap_pkg::result_t               result_reg, result_next;

    logic [tap_pkg::QUOT_W-1:0]     quot;
    logic [tap_pkg::POS_W-1:0]      set_tgt;
    logic                           done;
    logic                           ignored;
    logic [tap_pkg::PULSE_W-1:0]    pulse;

    assign quot    = tap_pkg::QUOT_W'(item.scaled) * tap_pkg::QUOT_W'(tap_pkg::RECIP);
    assign set_tgt = quot[tap_pkg::RECIP_SHIFT +: tap_pkg::POS_W];

    assign item_take = item_valid && (!out_valid_reg || m_ready);

    // next state
    always_comb begin
        logic signed [WORK_W-1:0] pos_s;
        logic signed [WORK_W-1:0] tgt_s;
        logic signed [WORK_W-1:0] trav_s;
        logic signed [WORK_W-1:0] work;
        pos_s     = $signed({2'b00, pos_reg});
        tgt_s     = $signed({2'b00, tgt_reg});
        trav_s    = $signed({2'b00, cfg.travel_time_ms});
        work      = pos_s;
        mode_next = mode_reg;
        pos_next  = pos_reg;
        tgt_next  = tgt_reg;
        done      = 1'b0;
        ignored   = 1'b0;
        if (item.cmd == tap_pkg::CMD_SET) begin
            tgt_next = set_tgt;
            if (mode_reg == tap_pkg::MODE_BOOT || mode_reg == tap_pkg::MODE_HOMING) begin
                ignored = 1'b1;
            end else if (set_tgt > pos_reg) begin
                mode_next = tap_pkg::MODE_OPENING;
            end else if (set_tgt < pos_reg) begin
                mode_next = tap_pkg::MODE_CLOSING;
            end
        end else begin
            case (mode_reg)
                tap_pkg::MODE_BOOT: begin
                    if (item.switch_closed) begin
                        pos_next  = '0;
                        tgt_next  = '0;
                        mode_next = tap_pkg::MODE_STOPPED;
                    end else if (item.switch_open) begin
                        pos_next  = cfg.travel_time_ms;
                        tgt_next  = cfg.travel_time_ms;
                        mode_next = tap_pkg::MODE_STOPPED;
                    end else begin
                        mode_next = tap_pkg::MODE_HOMING;
                    end
                end
                tap_pkg::MODE_HOMING: begin
                    if (item.switch_closed) begin
                        pos_next  = '0;
                        tgt_next  = '0;
                        mode_next = tap_pkg::MODE_STOPPED;
                        done      = 1'b1;
                    end
                end
                default: begin
                    if (mode_reg == tap_pkg::MODE_OPENING) begin
                        work = pos_s + $signed({2'b00, item.elapsed_ms});
                        if (work >= tgt_s || item.switch_open) begin
                            if (item.switch_open) begin
                                work = trav_s;
                            end
                            mode_next = tap_pkg::MODE_STOPPED;
                        end
                    end else if (mode_reg == tap_pkg::MODE_CLOSING) begin
                        work = pos_s - $signed({2'b00, item.elapsed_ms});
                        if (work <= tgt_s || item.switch_closed) begin
                            if (item.switch_closed) begin
                                work = '0;
                            end
                            mode_next = tap_pkg::MODE_STOPPED;
                        end
                    end
                    // clamp to 0..travel
                    if (work > trav_s) begin
                        work = trav_s;
                    end
                    if (work < 0) begin
                        work = '0;
                    end
                    pos_next = work[tap_pkg::POS_W-1:0];
                end
            endcase
        end
    end

    // outputs: pulse follows the new mode
    always_comb begin
        case (mode_next)
            tap_pkg::MODE_OPENING: pulse = cfg.forward_pulse_us;
            tap_pkg::MODE_CLOSING,
            tap_pkg::MODE_HOMING:  pulse = cfg.reverse_pulse_us;
            default:               pulse = cfg.stop_pulse_us;
        endcase
    end

    always_comb begin
        result_next.motor_pulse_us  = pulse;
        result_next.motion_state    = mode_next;
        result_next.position_ms     = pos_next;
        result_next.target_ms       = tgt_next;
        result_next.homing_done     = done;
        result_next.command_ignored = ignored;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= tap_pkg::MODE_BOOT;
            pos_reg       <= '0;
            tgt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (item_take) begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                tgt_reg  <= tgt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;

endmodule

// File: src/timed_actuator_position_controller_top.sv
`timescale 1ns / 1ps
// A request is held in the input register, then the motion update is written
//   into the result register, which drives m_tvalid.
// Throughput: 1 request per cycle while m_tready stays high; the update stage
//   and the result register advance together.
// Reset (aresetn low, synchronous): mode boot, position 0, target 0, registers
//   at 15000 / 1500 / 2000 / 1000, both pipeline registers empty.
// ----------------------------------------------------------------------------
// timed_actuator_position_controller_top: dead-reckoning servo controller
// Tracks a position estimate in ms of travel and drives a continuous-rotation
// servo toward a percent target, with limit-switch snapping and homing.
// ----------------------------------------------------------------------------
module timed_actuator_position_controller_top (
    input  logic                           aclk,
    input  logic                           aresetn,

    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [7:0] percent (signed),
                                                      // [23:8] elapsed_ms,
                                                      // [24] switch_open,
                                                      // [25] switch_closed,
                                                      // [31:26] zero
    input  logic                           s_tuser,   // [0] cmd: 0 tick, 1 set

    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [55:0]                    m_tdata,   // [11:0] motor_pulse_us,
                                                      // [14:12] motion_state,
                                                      // [30:15] position_ms,
                                                      // [46:31] target_ms,
                                                      // [47] homing_done,
                                                      // [48] command_ignored,
                                                      // [55:49] zero

    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tap_pkg::CFG_IDX_W-1:0]  cfg_index,  // 0 travel, 1 stop,
                                                       // 2 forward, 3 reverse
    input  logic [tap_pkg::POS_W-1:0]      cfg_wdata
);

    tap_pkg::cfg_t     cfg;
    tap_pkg::item_t    item;
    tap_pkg::result_t  result;
    logic              item_valid;
    logic              item_take;

    // Register writes are always accepted; they must only come while idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    tap_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Stage 1: unpack the request, saturate percent, multiply by travel.
    tap_in_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .cmd            (s_tuser),
        .percent        (s_tdata[7:0]),
        .elapsed_ms     (s_tdata[23:8]),
        .switch_open    (s_tdata[24]),
        .switch_closed  (s_tdata[25]),
        .travel_time_ms (cfg.travel_time_ms),
        .item_valid     (item_valid),
        .item_take      (item_take),
        .item           (item)
    );

    // Stage 2: divide by 100 (reciprocal multiply), update mode, position
    // and target, pick the pulse, and register the result. State moves only
    // when the result register takes the request, so back-to-back requests
    // always see the state left by the one before.
    tap_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result     (result)
    );

    assign m_tdata = {7'b0,
                      result.command_ignored,
                      result.homing_done,
                      result.target_ms,
                      result.position_ms,
                      result.motion_state,
                      result.motor_pulse_us};

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for timed_actuator_position_controller_top
// Table-driven directed requests (boot, homing, saturation, switch snapping),
// then random phases under several register settings. Every result is checked
// against a table expectation or a cycle-free predictor of mode, position and target.
// ----------------------------------------------------------------------------
module tb;

    localparam int RESET_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;  // well above the longest stall here
    localparam int DRAIN_CYCLES    = 8;     // result handshake trails the input and result registers
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int PRESSURE_AFTER  = 300;   // results seen before the long hold-off
    localparam int PRESSURE_CYCLES = 400;
    localparam int N_DIRECTED      = 24;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [31:0]                   s_tdata   = '0;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [55:0]                   m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tap_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tap_pkg::POS_W-1:0]     cfg_wdata = '0;

    timed_actuator_position_controller_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block's mode, estimate and registers.
    // ------------------------------------------------------------------
    tap_pkg::mode_t            est_mode;
    logic [tap_pkg::POS_W-1:0] est_position;
    logic [tap_pkg::POS_W-1:0] est_target;
    tap_pkg::cfg_t             est_cfg;

    tap_pkg::result_t expected_results[$];
    int      mismatches    = 0;
    int      results_seen  = 0;
    int      idle_cycles   = 0;
    bit      pressure_done = 1'b0;

    // One directed request; 'typed' rows carry a hand-written expectation.
    typedef struct {
        logic              cmd;
        logic signed [7:0] percent;
        logic [15:0]       elapsed_ms;
        logic              sw_open;
        logic              sw_closed;
        bit                typed;
        tap_pkg::result_t  want;
    } directed_row_t;

    // Travel stays at its reset value of 15000 for the whole table.
    directed_row_t directed_rows [N_DIRECTED] = '{
        // set during boot: target stored, motion untouched, flagged ignored
        '{tap_pkg::CMD_SET,    50,     0, 0, 0, 1,
          '{12'd1500, tap_pkg::MODE_BOOT,    16'd0, 16'd7500, 1'b0, 1'b1}},
        // first tick with no switch: start homing, elapsed unused
        '{tap_pkg::CMD_TICK,    0, 65535, 0, 0, 1,
          '{12'd1000, tap_pkg::MODE_HOMING,  16'd0, 16'd7500, 1'b0, 1'b0}},
        // set during homing, most negative percent saturates to zero
        '{tap_pkg::CMD_SET,  -128,     0, 0, 0, 1,
          '{12'd1000, tap_pkg::MODE_HOMING,  16'd0, 16'd0,    1'b0, 1'b1}},
        // open switch does not end homing
        '{tap_pkg::CMD_TICK,    0,  1234, 1, 0, 1,
          '{12'd1000, tap_pkg::MODE_HOMING,  16'd0, 16'd0,    1'b0, 1'b0}},
        // closed switch ends homing
        '{tap_pkg::CMD_TICK,    0,     0, 0, 1, 1,
          '{12'd1500, tap_pkg::MODE_STOPPED, 16'd0, 16'd0,    1'b1, 1'b0}},
        // largest percent saturates to 100
        '{tap_pkg::CMD_SET,   127,     0, 0, 0, 1,
          '{12'd2000, tap_pkg::MODE_OPENING, 16'd0, 16'd15000, 1'b0, 1'b0}},
        '{tap_pkg::CMD_TICK,    0,  5000, 0, 0, 0, '0},
        // set in the direction already moving keeps opening
        '{tap_pkg::CMD_SET,   101,     0, 0, 0, 0, '0},
        // overshoot past the target stops and clamps to travel
        '{tap_pkg::CMD_TICK,    0, 65535, 0, 0, 1,
          '{12'd1500, tap_pkg::MODE_STOPPED, 16'd15000, 16'd15000, 1'b0, 1'b0}},
        // set equal to position leaves the mode alone
        '{tap_pkg::CMD_SET,   100,     0, 0, 0, 0, '0},
        '{tap_pkg::CMD_SET,     0,     0, 0, 0, 1,
          '{12'd1000, tap_pkg::MODE_CLOSING, 16'd15000, 16'd0, 1'b0, 1'b0}},
        '{tap_pkg::CMD_SET,     1,     0, 0, 0, 0, '0},
        // both switches while closing: only the closed one counts
        '{tap_pkg::CMD_TICK,    0,   100, 1, 1, 0, '0},
        '{tap_pkg::CMD_SET,   127,     0, 0, 0, 0, '0},
        // both switches while opening: snaps to travel
        '{tap_pkg::CMD_TICK,    0,     0, 1, 1, 0, '0},
        '{tap_pkg::CMD_SET,    -1,     0, 0, 0, 0, '0},
        '{tap_pkg::CMD_TICK,    0,     0, 0, 0, 0, '0},
        // undershoot below zero stops and clamps
        '{tap_pkg::CMD_TICK,    0, 20000, 0, 0, 0, '0},
        // stopped tick ignores switches, clamp only
        '{tap_pkg::CMD_TICK,    0, 65535, 1, 1, 0, '0},
        '{tap_pkg::CMD_SET,    33,     0, 0, 0, 0, '0},
        '{tap_pkg::CMD_TICK,    0,  4949, 0, 0, 0, '0},
        // open switch snaps the estimate up to full travel
        '{tap_pkg::CMD_TICK,    0,     1, 1, 0, 0, '0},
        '{tap_pkg::CMD_SET,    64,     0, 0, 0, 0, '0},
        // open switch is ignored while closing
        '{tap_pkg::CMD_TICK,    0,     0, 1, 0, 0, '0}
    };

    // Applies one request to the predictor state and returns its result.
    function automatic tap_pkg::result_t predict_motion(input logic cmd,
                                                        input logic signed [7:0] pct,
                                                        input logic [15:0] elapsed,
                                                        input logic sw_open,
                                                        input logic sw_closed);
        tap_pkg::result_t r;
        int      travel;
        int      pos;
        int      pct_sat;
        r      = '0;
        travel = int'(est_cfg.travel_time_ms);
        if (cmd == tap_pkg::CMD_SET) begin
            pct_sat = int'(pct);
            if (pct_sat < 0) pct_sat = 0;
            if (pct_sat > 100) pct_sat = 100;
            est_target = 16'((pct_sat * travel) / 100);
            if (est_mode == tap_pkg::MODE_BOOT || est_mode == tap_pkg::MODE_HOMING) begin
                r.command_ignored = 1'b1;
            end else if (est_target > est_position) begin
                est_mode = tap_pkg::MODE_OPENING;
            end else if (est_target < est_position) begin
                est_mode = tap_pkg::MODE_CLOSING;
            end
        end else begin
            case (est_mode)
                tap_pkg::MODE_BOOT: begin
                    if (sw_closed) begin
                        est_position = '0;
                        est_target   = '0;
                        est_mode     = tap_pkg::MODE_STOPPED;
                    end else if (sw_open) begin
                        est_position = est_cfg.travel_time_ms;
                        est_target   = est_cfg.travel_time_ms;
                        est_mode     = tap_pkg::MODE_STOPPED;
                    end else begin
                        est_mode = tap_pkg::MODE_HOMING;
                    end
                end
                tap_pkg::MODE_HOMING: begin
                    if (sw_closed) begin
                        est_position  = '0;
                        est_target    = '0;
                        est_mode      = tap_pkg::MODE_STOPPED;
                        r.homing_done = 1'b1;
                    end
                end
                default: begin
                    pos = int'(est_position);
                    if (est_mode == tap_pkg::MODE_OPENING) begin
                        pos += int'(elapsed);
                        if (pos >= int'(est_target) || sw_open) begin
                            if (sw_open) pos = travel;
                            est_mode = tap_pkg::MODE_STOPPED;
                        end
                    end else if (est_mode == tap_pkg::MODE_CLOSING) begin
                        pos -= int'(elapsed);
                        if (pos <= int'(est_target) || sw_closed) begin
                            if (sw_closed) pos = 0;
                            est_mode = tap_pkg::MODE_STOPPED;
                        end
                    end
                    if (pos > travel) pos = travel;
                    if (pos < 0) pos = 0;
                    est_position = 16'(pos);
                end
            endcase
        end
        case (est_mode)
            tap_pkg::MODE_OPENING:
                r.motor_pulse_us = est_cfg.forward_pulse_us;
            tap_pkg::MODE_CLOSING, tap_pkg::MODE_HOMING:
                r.motor_pulse_us = est_cfg.reverse_pulse_us;
            default:
                r.motor_pulse_us = est_cfg.stop_pulse_us;
        endcase
        r.motion_state = est_mode;
        r.position_ms  = est_position;
        r.target_ms    = est_target;
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offers one request and returns at the edge where it is taken.
    // tvalid stays high afterwards so back-to-back requests need no toggle.
    task automatic send_request(input logic cmd, input logic signed [7:0] pct,
                                input logic [15:0] elapsed, input logic sw_open,
                                input logic sw_closed, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, sw_closed, sw_open, elapsed, pct};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_register(input logic [tap_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            tap_pkg::CFG_TRAVEL:  est_cfg.travel_time_ms   = value;
            tap_pkg::CFG_STOP:    est_cfg.stop_pulse_us    = value[tap_pkg::PULSE_W-1:0];
            tap_pkg::CFG_FORWARD: est_cfg.forward_pulse_us = value[tap_pkg::PULSE_W-1:0];
            default:              est_cfg.reverse_pulse_us = value[tap_pkg::PULSE_W-1:0];
        endcase
    endtask

    // Random request shaped like real use: sets mostly while stopped, ticks
    // sized to the travel, switches that mostly fire when an end is reached.
    task automatic send_random_request(input bit steady);
        logic              cmd;
        logic signed [7:0] pct;
        logic [15:0]       elapsed;
        logic              sw_o;
        logic              sw_c;
        int                travel;
        int                pos;
        int                roll;
        travel = int'(est_cfg.travel_time_ms);
        pos    = int'(est_position);
        roll   = $urandom_range(0, 99);
        if (est_mode == tap_pkg::MODE_STOPPED)
            cmd = (roll < 55) ? tap_pkg::CMD_SET : tap_pkg::CMD_TICK;
        else
            cmd = (roll < 10) ? tap_pkg::CMD_SET : tap_pkg::CMD_TICK;
        if ($urandom_range(0, 99) < 85) pct = 8'($urandom_range(0, 100));
        else pct = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 70) elapsed = 16'($urandom_range(0, travel / 6 + 1));
        else if (roll < 85) elapsed = '0;
        else if (roll < 95) elapsed = 16'($urandom_range(0, 65535));
        else elapsed = 16'hFFFF;
        // background noise on the switches
        sw_o = ($urandom_range(0, 19) == 0);
        sw_c = ($urandom_range(0, 19) == 0);
        if (est_mode == tap_pkg::MODE_OPENING && pos + int'(elapsed) >= travel
            && $urandom_range(0, 1))
            sw_o = 1'b1;
        if (est_mode == tap_pkg::MODE_CLOSING && pos <= int'(elapsed) && $urandom_range(0, 1))
            sw_c = 1'b1;
        expected_results.push_back(predict_motion(cmd, pct, elapsed, sw_o, sw_c));
        send_request(cmd, pct, elapsed, sw_o, sw_c, steady ? 0 : pick_gap());
    endtask

    // ------------------------------------------------------------------
    // Request side: reset, directed table, then random phases.
    // ------------------------------------------------------------------
    initial begin
        tap_pkg::result_t r;
        logic [15:0] travel;
        logic [15:0] stop_p;
        logic [15:0] fwd_p;
        logic [15:0] rev_p;
        bit          steady;
        est_cfg      = '{tap_pkg::TRAVEL_RESET, tap_pkg::STOP_RESET,
                         tap_pkg::FORWARD_RESET, tap_pkg::REVERSE_RESET};
        est_mode     = tap_pkg::MODE_BOOT;
        est_position = '0;
        est_target   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            r = predict_motion(directed_rows[i].cmd, directed_rows[i].percent,
                               directed_rows[i].elapsed_ms, directed_rows[i].sw_open,
                               directed_rows[i].sw_closed);
            expected_results.push_back(directed_rows[i].typed ? directed_rows[i].want : r);
            send_request(directed_rows[i].cmd, directed_rows[i].percent,
                         directed_rows[i].elapsed_ms, directed_rows[i].sw_open,
                         directed_rows[i].sw_closed, pick_gap());
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // registers only change once the pipeline has drained
            s_tvalid <= 1'b0;
            while (expected_results.size() != 0) @(posedge aclk);
            case (phase)
                0: begin
                    travel = 16'd1;
                    stop_p = 16'd500;
                    fwd_p  = 16'd2500;
                    rev_p  = 16'd500;
                end
                1: begin
                    travel = 16'd65535;
                    stop_p = 16'd2500;
                    fwd_p  = 16'd500;
                    rev_p  = 16'd2500;
                end
                default: begin
                    // shrinking travel leaves old targets beyond the end
                    if (phase == 2 || $urandom_range(0, 1)) travel = 16'($urandom_range(2, 300));
                    else travel = 16'($urandom_range(1, 65535));
                    stop_p = 16'($urandom_range(500, 2500));
                    fwd_p  = 16'($urandom_range(500, 2500));
                    rev_p  = 16'($urandom_range(500, 2500));
                end
            endcase
            write_register(tap_pkg::CFG_TRAVEL, travel);
            write_register(tap_pkg::CFG_STOP, stop_p);
            write_register(tap_pkg::CFG_FORWARD, fwd_p);
            write_register(tap_pkg::CFG_REVERSE, rev_p);
            cfg_valid <= 1'b0;
            steady = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) send_random_request(steady);
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: bursts of ready, random stalls, and one
    // long hold-off so the block fills and pushes back on s_tready.
    // ------------------------------------------------------------------
    initial begin
        int burst;
        int gap;
        @(posedge aclk);
        forever begin
            if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge aclk);
                pressure_done = 1'b1;
            end
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            m_tready <= 1'b1;
            // cut the burst short once the hold-off is due, while requests
            // are still being offered
            while (burst > 0 && (pressure_done || results_seen < PRESSURE_AFTER)) begin
                @(posedge aclk);
                burst--;
            end
            if (!pressure_done && results_seen >= PRESSURE_AFTER) continue;
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        tap_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: m_tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("motor_pulse_us", 16'(want.motor_pulse_us), 16'(m_tdata[11:0]));
                compare_field("motion_state", 16'(want.motion_state), 16'(m_tdata[14:12]));
                compare_field("position_ms", want.position_ms, m_tdata[30:15]);
                compare_field("target_ms", want.target_ms, m_tdata[46:31]);
                compare_field("homing_done", 16'(want.homing_done), 16'(m_tdata[47]));
                compare_field("command_ignored", 16'(want.command_ignored), 16'(m_tdata[48]));
            end
        end
    end

    // Ends the run if no handshake of any kind happens for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// File: filelist.f
src/tap_pkg.sv
src/tap_cfg_regs.sv
src/tap_in_stage.sv
src/tap_core.sv
src/timed_actuator_position_controller_top.sv
tb/tb.sv
